// ===== rtl/indexed_pixel_row_repacker_macros.svh =====
// Assertion macros shared by the pixel row repacker modules.
`ifndef INDEXED_PIXEL_ROW_REPACKER_MACROS_SVH
`define INDEXED_PIXEL_ROW_REPACKER_MACROS_SVH
`ifndef SYNTHESIS
`define IPR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipr assertion failed");
`define IPR_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("ipr assertion failed");
`else
`define IPR_ASSERT(label, clk, rst_n, prop)
`define IPR_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== rtl/ipr_pkg.sv =====
// Types and constants of the indexed pixel row repacker.
package ipr_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned LB_W        = 2;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned BITS_W      = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned APB_W       = 32;

    localparam logic [1:0] REG_LOG2_BPP  = 2'd0;
    localparam logic [1:0] REG_CROP_X    = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] end_slot;
        logic              done;
        logic              eor;
        logic              eor_short;
    } t_entry;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              row_done;
        logic              short_row;
        logic              run_last;
    } t_result;

endpackage

// ===== rtl/ipr_front.sv =====
// Front end: accepts source words and finds the kept pixel slots of each.
module ipr_front #(
    parameter int POS_WIDTH = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ipr_pkg::WORD_W-1:0]        i_word,
    input  logic                              i_eor,
    input  logic [ipr_pkg::LB_W-1:0]          i_log2_bpp,
    input  logic [ipr_pkg::CFG_W-1:0]         i_crop_x,
    input  logic [ipr_pkg::CFG_W-1:0]         i_row_width,
    input  logic                              i_full,
    output logic                              o_push,
    output ipr_pkg::t_entry                   o_entry
);

    localparam int EW = ((POS_WIDTH > 17) ? POS_WIDTH : 17) + 1;

    logic [POS_WIDTH-1:0] r_pos;
    logic [POS_WIDTH-1:0] n_pos;
    logic                 r_fin;
    logic                 n_fin;

    logic [EW-1:0] w_pos;
    logic [EW-1:0] w_crop;
    logic [EW-1:0] w_win_end;
    logic [EW-1:0] w_pos_max;
    logic [EW-1:0] w_npix;
    logic [EW-1:0] w_pos_end;
    logic [EW-1:0] w_lim;
    logic [EW-1:0] w_hi;
    logic [EW-1:0] w_lo;
    logic [EW-1:0] w_sat_end;
    logic          w_keep;
    logic          w_done;
    logic          w_accept;

    assign w_pos     = EW'(r_pos);
    assign w_crop    = EW'(i_crop_x);
    assign w_win_end = EW'(i_crop_x) + EW'(i_row_width);
    assign w_pos_max = EW'({POS_WIDTH{1'b1}});
    assign w_npix    = EW'(ipr_pkg::WORD_W) >> i_log2_bpp;
    assign w_pos_end = w_pos + w_npix;
    assign w_lim     = (w_win_end < w_pos_max) ? w_win_end : w_pos_max;
    assign w_hi      = (w_lim < w_pos_end) ? w_lim : w_pos_end;
    assign w_lo      = (w_crop > w_pos) ? w_crop : w_pos;
    assign w_sat_end = (w_pos_end < w_pos_max) ? w_pos_end : w_pos_max;
    assign w_keep    = !r_fin && (w_hi > w_lo);
    assign w_done    = w_keep && (w_hi == w_win_end);

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    always_comb begin
        o_entry.word       = i_word;
        o_entry.first_slot = w_keep ? ipr_pkg::SLOT_W'(w_lo - w_pos) : '0;
        o_entry.end_slot   = w_keep ? ipr_pkg::SLOT_W'(w_hi - w_pos) : '0;
        o_entry.done       = w_done;
        o_entry.eor        = i_eor;
        o_entry.eor_short  = i_eor && !(r_fin || w_done) && (i_row_width != '0);
    end

    always_comb begin
        n_pos = i_eor ? '0 : w_sat_end[POS_WIDTH-1:0];
        n_fin = i_eor ? 1'b0 : (r_fin || w_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_fin <= 1'b0;
        end else if (w_accept) begin
            r_pos <= n_pos;
            r_fin <= n_fin;
        end
    end

endmodule

// ===== rtl/ipr_queue.sv =====
// Short word queue between the front end and the packer.
`include "indexed_pixel_row_repacker_macros.svh"

module ipr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ipr_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output ipr_pkg::t_entry o_entry,
    input  logic            i_pop
);

    localparam int PTR_W = $clog2(ipr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    ipr_pkg::t_entry r_mem [ipr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign o_full  = (r_count == CNT_W'(ipr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(ipr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(ipr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `IPR_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> (r_count != '0))
    `IPR_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full)

endmodule

// ===== rtl/ipr_back.sv =====
// Packer: repacks kept pixels MSB first, at most one byte per cycle unless stalled.
`include "indexed_pixel_row_repacker_macros.svh"

module ipr_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  ipr_pkg::t_entry          i_entry,
    output logic                     o_pop,
    input  logic [ipr_pkg::LB_W-1:0] i_log2_bpp,
    output logic                     o_valid,
    output ipr_pkg::t_result         o_result,
    input  logic                     i_ready
);

    localparam int SW = ipr_pkg::SLOT_W;
    localparam int BW = ipr_pkg::BITS_W;

    function automatic logic [7:0] pix_reverse(input logic [7:0] g, input logic [1:0] lb);
        logic [7:0] r;
        case (lb)
            2'd0:    r = {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]};
            2'd1:    r = {g[1:0], g[3:2], g[5:4], g[7:6]};
            2'd2:    r = {g[3:0], g[7:4]};
            default: r = g;
        endcase
        return r;
    endfunction

    logic [SW-1:0]             r_cur;
    logic                      r_fresh;
    logic [7:0]                r_accum;
    logic [BW-1:0]             r_bits;
    logic                      r_out_valid;
    ipr_pkg::t_result          r_out;

    logic [SW-1:0]             n_cur;
    logic                      n_fresh;
    logic [7:0]                n_accum;
    logic [BW-1:0]             n_bits;

    logic                      w_step;
    logic [SW-1:0]             w_c;
    logic [SW-1:0]             w_rem;
    logic [SW-1:0]             w_rem_n;
    logic [BW-1:0]             w_bpp;
    logic                      w_flush;
    logic [BW-1:0]             w_fit;
    logic [BW-1:0]             w_n;
    logic [BW-1:0]             w_nb;
    logic [7:0]                w_sh;
    logic [7:0]                w_grab;
    logic [7:0]                w_mask;
    logic [7:0]                w_acc;
    logic [BW-1:0]             w_bits_n;
    logic                      w_end;
    logic                      w_reach_done;
    logic                      w_full_byte;
    logic                      w_more_flush;
    logic                      w_more_byte;
    logic                      w_emit;
    ipr_pkg::t_result          w_res;

    assign w_step  = i_valid && (!r_out_valid || i_ready);
    assign w_c     = r_fresh ? i_entry.first_slot : r_cur;
    assign w_rem   = i_entry.end_slot - w_c;
    assign w_bpp   = BW'(1) << i_log2_bpp;
    assign w_flush = (w_rem != '0) && ((r_bits + w_bpp) > BW'(8));

    assign w_fit    = (BW'(8) - r_bits) >> i_log2_bpp;
    assign w_n      = (w_rem < SW'(w_fit)) ? w_rem[BW-1:0] : w_fit;
    assign w_nb     = w_n << i_log2_bpp;
    assign w_rem_n  = w_rem - SW'(w_n);
    assign w_sh     = 8'(w_c) << i_log2_bpp;
    assign w_grab   = 8'(i_entry.word >> w_sh[4:0]);
    assign w_mask   = ~(8'hFF >> w_nb);
    assign w_acc    = r_accum | ((pix_reverse(w_grab, i_log2_bpp) & w_mask) >> r_bits);
    assign w_bits_n = r_bits + w_nb;

    assign w_end        = (w_rem_n == '0);
    assign w_reach_done = w_end && i_entry.done;
    assign w_full_byte  = (w_bits_n == BW'(8)) || w_reach_done;

    assign w_more_flush = ((9'(w_rem) << i_log2_bpp) >= 9'd8) || i_entry.done
                          || i_entry.eor_short;
    assign w_more_byte  = (w_rem_n != '0) && (((9'(w_rem_n) << i_log2_bpp) >= 9'd8)
                          || i_entry.done || i_entry.eor_short);

    always_comb begin
        w_emit  = 1'b0;
        w_res   = '0;
        n_cur   = r_cur;
        n_fresh = r_fresh;
        n_accum = r_accum;
        n_bits  = r_bits;
        if (w_flush) begin
            w_emit         = 1'b1;
            w_res.data     = r_accum;
            w_res.run_last = !w_more_flush;
            n_cur          = w_c;
            n_fresh        = 1'b0;
            n_accum        = '0;
            n_bits         = '0;
        end else begin
            if (w_full_byte) begin
                w_emit          = 1'b1;
                w_res.data      = w_acc;
                w_res.row_done  = w_reach_done || (w_end && i_entry.eor_short);
                w_res.short_row = w_end && i_entry.eor_short;
                w_res.run_last  = !w_more_byte;
            end else if (w_end && i_entry.eor_short) begin
                w_emit          = 1'b1;
                w_res.data      = w_acc;
                w_res.row_done  = 1'b1;
                w_res.short_row = 1'b1;
                w_res.run_last  = 1'b1;
            end
            if (w_full_byte || (w_end && i_entry.eor)) begin
                n_accum = '0;
                n_bits  = '0;
            end else begin
                n_accum = w_acc;
                n_bits  = w_bits_n;
            end
            if (w_end) begin
                n_fresh = 1'b1;
            end else begin
                n_cur   = w_c + SW'(w_n);
                n_fresh = 1'b0;
            end
        end
    end

    assign o_pop    = w_step && !w_flush && w_end;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_fresh     <= 1'b1;
            r_accum     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_cur   <= n_cur;
                r_fresh <= n_fresh;
                r_accum <= n_accum;
                r_bits  <= n_bits;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_res;
        end
    end

    `IPR_ASSERT(a_short_has_done, i_clk, i_rst_n, (r_out_valid && r_out.short_row) |-> r_out.row_done)
    `IPR_ASSERT_NEXT(a_eor_clears, i_clk, i_rst_n, o_pop && i_entry.eor, r_bits == '0)

endmodule

// ===== rtl/indexed_pixel_row_repacker.sv =====
// Top level: configuration registers, front end, word queue and packer.
// A word's first byte passes the word queue and the packer output register before it is shown.
// Throughput: at most one output byte per cycle unless the output stalls; a word takes one packer
// step per output byte, one for a partial remainder and one for a pixel size change mid-byte.
// Reset: synchronous, active low; clears position, queue and accumulator and
// loads log2_bpp 0, crop_x 0, row_width 1.
module indexed_pixel_row_repacker #(
    parameter int POS_WIDTH = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipr_pkg::APB_W-1:0]   pwdata,
    output logic [ipr_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] src_word
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tlast,
    output logic [1:0]                  m_axis_tuser    // [0] short_row, [1] run_last
);

    logic [ipr_pkg::LB_W-1:0]  r_log2_bpp;
    logic [ipr_pkg::CFG_W-1:0] r_crop_x;
    logic [ipr_pkg::CFG_W-1:0] r_row_width;

    logic             w_cfg_wr;
    logic [1:0]       w_reg_idx;
    logic             w_push;
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;
    ipr_pkg::t_entry  w_in_entry;
    ipr_pkg::t_entry  w_head;
    ipr_pkg::t_result w_result;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_bpp  <= '0;
            r_crop_x    <= '0;
            r_row_width <= ipr_pkg::CFG_W'(1);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                ipr_pkg::REG_LOG2_BPP:  r_log2_bpp  <= pwdata[ipr_pkg::LB_W-1:0];
                ipr_pkg::REG_CROP_X:    r_crop_x    <= pwdata[ipr_pkg::CFG_W-1:0];
                ipr_pkg::REG_ROW_WIDTH: r_row_width <= pwdata[ipr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            ipr_pkg::REG_LOG2_BPP:  prdata = ipr_pkg::APB_W'(r_log2_bpp);
            ipr_pkg::REG_CROP_X:    prdata = ipr_pkg::APB_W'(r_crop_x);
            ipr_pkg::REG_ROW_WIDTH: prdata = ipr_pkg::APB_W'(r_row_width);
            default:                prdata = '0;
        endcase
    end

    ipr_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_word      (s_axis_tdata),
        .i_eor       (s_axis_tlast),
        .i_log2_bpp  (r_log2_bpp),
        .i_crop_x    (r_crop_x),
        .i_row_width (r_row_width),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    ipr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head),
        .i_pop   (w_pop)
    );

    ipr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_entry    (w_head),
        .o_pop      (w_pop),
        .i_log2_bpp (r_log2_bpp),
        .o_valid    (m_axis_tvalid),
        .o_result   (w_result),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = w_result.data;
    assign m_axis_tlast = w_result.row_done;
    assign m_axis_tuser = {w_result.run_last, w_result.short_row};

endmodule

// ===== tb/ipr_byte_checker.sv =====
// Predicts the packed output bytes of the repacker and checks every byte that leaves it.
`timescale 1ns / 100ps
module ipr_byte_checker #(
    parameter int POS_WIDTH = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [ipr_pkg::ADDR_W-1:0] i_paddr,
    input  logic [ipr_pkg::APB_W-1:0]  i_pwdata,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [31:0]                i_s_tdata,   // [31:0] src_word
    input  logic                       i_s_tlast,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [7:0]                 i_m_tdata,   // [7:0] out_byte
    input  logic                       i_m_tlast,
    input  logic [1:0]                 i_m_tuser,   // [0] short_row, [1] run_last
    output int                         o_failures,
    output int                         o_pending
);

    localparam int unsigned POS_LIMIT = (1 << POS_WIDTH) - 1;
    localparam int          SHOWN_MAX = 10;

    logic [1:0]  bpp_log    = '0;
    logic [15:0] crop_start = '0;
    logic [15:0] keep_width = 16'd1;

    logic [7:0]  accum      = '0;
    int unsigned fill       = 0;
    int unsigned position   = 0;
    bit          finished   = 1'b0;

    ipr_pkg::t_result bytes_due[$];
    int               mismatches = 0;

    task automatic repack_word(input logic [31:0] word, input logic eor);
        ipr_pkg::t_result run[$];
        int unsigned bits;
        int unsigned count;
        int unsigned pmask;
        int unsigned win_end;
        int unsigned idx;
        int unsigned pix;
        bit          last_pix;
        bits    = 1 << bpp_log;
        count   = 32 >> bpp_log;
        pmask   = (1 << bits) - 1;
        win_end = int'(crop_start) + int'(keep_width);
        for (int k = 0; k < count; k++) begin
            pix = (word >> (k * bits)) & pmask;
            idx = position;
            if (idx < POS_LIMIT) position = idx + 1;
            if (finished || idx >= POS_LIMIT || idx < crop_start || idx >= win_end) continue;
            if (fill + bits > 8) begin
                run.push_back('{accum, 1'b0, 1'b0, 1'b0});
                accum = '0;
                fill  = 0;
            end
            accum    = accum | 8'(pix << (8 - bits - fill));
            fill     = fill + bits;
            last_pix = (idx == win_end - 1);
            if (fill == 8 || last_pix) begin
                run.push_back('{accum, last_pix, 1'b0, 1'b0});
                accum = '0;
                fill  = 0;
                if (last_pix) finished = 1'b1;
            end
        end
        if (eor) begin
            if (!finished && keep_width != 0) begin
                if (fill != 0) begin
                    run.push_back('{accum, 1'b1, 1'b1, 1'b0});
                end else if (run.size() > 0) begin
                    run[run.size()-1].row_done  = 1'b1;
                    run[run.size()-1].short_row = 1'b1;
                end else begin
                    run.push_back('{8'h00, 1'b1, 1'b1, 1'b0});
                end
            end
            accum    = '0;
            fill     = 0;
            position = 0;
            finished = 1'b0;
        end
        if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
        foreach (run[j]) bytes_due.push_back(run[j]);
    endtask

    always @(posedge i_clk) begin
        ipr_pkg::t_result got;
        ipr_pkg::t_result want;
        if (!i_rst_n) begin
            bpp_log    = '0;
            crop_start = '0;
            keep_width = 16'd1;
            accum      = '0;
            fill       = 0;
            position   = 0;
            finished   = 1'b0;
            bytes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    ipr_pkg::REG_LOG2_BPP:  bpp_log    = i_pwdata[1:0];
                    ipr_pkg::REG_CROP_X:    crop_start = i_pwdata[15:0];
                    ipr_pkg::REG_ROW_WIDTH: keep_width = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata, i_m_tlast, i_m_tuser[0], i_m_tuser[1]};
                if (bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("unexpected word: byte %02h done %0b short %0b last %0b",
                                 got.data, got.row_done, got.short_row, got.run_last);
                end else begin
                    want = bytes_due.pop_front();
                    if (got.data !== want.data || got.row_done !== want.row_done ||
                        got.short_row !== want.short_row || got.run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX)
                            $display({"mismatch: expected byte %02h done %0b short %0b last %0b,",
                                      " got byte %02h done %0b short %0b last %0b"},
                                     want.data, want.row_done, want.short_row, want.run_last,
                                     got.data, got.row_done, got.short_row, got.run_last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) repack_word(i_s_tdata, i_s_tlast);
        end
        o_pending  = bytes_due.size();
        o_failures = mismatches + bytes_due.size();
    end

endmodule

// ===== tb/tb_indexed_pixel_row_repacker.sv =====
// Stimulus and verdict for the indexed pixel row repacker.
`timescale 1ns / 100ps
module tb_indexed_pixel_row_repacker;

    localparam int         POS_WIDTH      = 17;
    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         PHASE_WORDS    = 140;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         PRESSURE_WORDS = 12;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [ipr_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [ipr_pkg::APB_W-1:0]    pwdata         = '0;
    logic [ipr_pkg::APB_W-1:0]    prdata;
    logic                         pready;
    logic                         s_axis_tvalid  = 1'b0;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata   = '0;  // [31:0] src_word
    logic                         s_axis_tlast   = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready  = 1'b0;
    logic [7:0]                   m_axis_tdata;         // [7:0] out_byte
    logic                         m_axis_tlast;
    logic [1:0]                   m_axis_tuser;         // [0] short_row, [1] run_last

    int   tx_idle_pct = 38;
    int   rx_idle_pct = 83;
    logic hold_go     = 1'b0;
    logic hold_rx     = 1'b0;
    int   words_sent  = 0;
    int   failures;
    int   pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    indexed_pixel_row_repacker #(.POS_WIDTH(POS_WIDTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    ipr_byte_checker #(.POS_WIDTH(POS_WIDTH)) u_byte_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_m_tuser  (m_axis_tuser),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial begin
        wait (hold_go);
        @(negedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_indexed_pixel_row_repacker: errors");
        $finish;
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] word, input logic eor);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= eor;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [1:0] bpp, input logic [15:0] crop,
                             input logic [15:0] width);
        drain();
        apb_write(ipr_pkg::REG_LOG2_BPP, 32'(bpp));
        apb_write(ipr_pkg::REG_CROP_X, 32'(crop));
        apb_write(ipr_pkg::REG_ROW_WIDTH, 32'(width));
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_setting();
        logic [15:0] crop;
        logic [15:0] width;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) crop = 16'($urandom_range(0, 40));
        else if (pick < 9) crop = 16'($urandom_range(0, 600));
        else crop = 16'hFFFF;
        case ($urandom_range(0, 9))
            0: width = 16'd0;
            1: width = 16'd1;
            2: width = 16'hFFFF;
            default: width = 16'($urandom_range(2, 120));
        endcase
        configure(2'($urandom_range(0, 3)), crop, width);
        if ($urandom_range(0, 7) == 0) apb_write(REG_SPARE, $urandom);
    endtask

    task automatic play_row();
        int unsigned n_words;
        if ($urandom_range(0, 4) == 0) random_setting();
        n_words = $urandom_range(1, 12);
        for (int i = 0; i < n_words; i++) begin
            if (i > 0 && $urandom_range(0, 15) == 0) begin
                drain();
                apb_write(ipr_pkg::REG_LOG2_BPP, 32'($urandom_range(0, 3)));
            end
            send_word(pick_word(), i == n_words - 1);
        end
    endtask

    task automatic play_phase(input int tx_pct, input int rx_pct);
        int phase_end;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        phase_end = words_sent + PHASE_WORDS;
        random_setting();
        while (words_sent < phase_end) play_row();
    endtask

    initial begin
        int wait_cnt;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(32'hFFFF_FFFF, 1'b1);

        configure(2'd3, 16'd0, 16'd5);
        send_word(32'h4433_2211, 1'b0);
        send_word(32'h0000_00AA, 1'b0);
        send_word(32'h1234_5678, 1'b1);

        configure(2'd1, 16'd3, 16'd20);
        send_word(32'hAAAA_5555, 1'b1);

        configure(2'd2, 16'd0, 16'd20);
        send_word(32'h8765_4321, 1'b1);

        configure(2'd0, 16'd100, 16'd5);
        send_word(32'hFFFF_FFFF, 1'b1);

        configure(2'd3, 16'd0, 16'd0);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        send_word(32'hDEAD_BEEF, 1'b1);

        configure(2'd0, 16'd3, 16'd40);
        send_word(32'hF0F0_F0F1, 1'b0);
        drain();
        apb_write(ipr_pkg::REG_LOG2_BPP, 32'd2);
        send_word(32'h1234_5678, 1'b1);

        configure(2'd3, 16'd0, 16'hFFFF);
        send_word(32'h0102_0304, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        configure(2'd2, 16'd7, 16'd1);
        send_word(32'hF000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);

        configure(2'd3, 16'd0, 16'hFFFF);
        hold_go <= 1'b1;
        repeat (PRESSURE_WORDS) send_word(pick_word(), 1'b0);
        send_word(pick_word(), 1'b1);

        play_phase(38, 83);
        play_phase(83, 38);
        play_phase(0, 0);

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 200_000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0)
            $display("tb_indexed_pixel_row_repacker: clean");
        else
            $display("tb_indexed_pixel_row_repacker: errors");
        $finish;
    end

endmodule

// ===== indexed_pixel_row_repacker.f =====
+incdir+rtl
rtl/ipr_pkg.sv
rtl/ipr_front.sv
rtl/ipr_queue.sv
rtl/ipr_back.sv
rtl/indexed_pixel_row_repacker.sv
tb/ipr_byte_checker.sv
tb/tb_indexed_pixel_row_repacker.sv
